// ===== rtl/ipst_pkg.sv =====
// ----------------------------------------------------------------------------
// ipst_pkg
// Types and constants shared by the sorted IPv4 prefix table.
// ----------------------------------------------------------------------------
package ipst_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = IDX_W + 1;
    localparam int ENTRY_W     = 32 + 8 + 6;

    typedef enum logic [1:0]
    {
        KIND_BEGIN  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_COMMIT = 2'd2,
        KIND_LOOKUP = 2'd3
    } kind_t;

    typedef enum logic [1:0]
    {
        ST_DONE = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_WT,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WT,
        S_SHIFT_WR,
        S_PUT,
        S_LK_RD,
        S_LK_WT,
        S_LK_CMP,
        S_OUT
    } state_t;

    typedef struct packed
    {
        logic load_item;
        logic srch_init;
        logic srch_rd;
        logic srch_step;
        logic shift_rd;
        logic shift_wr;
        logic put;
        logic lk_rd;
        logic lk_eval;
        logic set_begin;
        logic set_commit;
        logic set_status;
        logic publish;
        status_t status;
    } ipst_cmd_t;

    typedef struct packed
    {
        kind_t kind;
        logic  srch_done;
        logic  found_dup;
        logic  full;
        logic  shift_done;
        logic  lk_skip;
    } ipst_stat_t;

endpackage

// ===== rtl/ipst_ram.sv =====
// ----------------------------------------------------------------------------
// ipst_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ipst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/ipst_datapath.sv =====
// ----------------------------------------------------------------------------
// ipst_datapath
// Bank counters, search bounds, entry RAM and result registers.
// ----------------------------------------------------------------------------
module ipst_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               table_enable,
    input  logic [1:0]         kind,
    input  logic [31:0]        net_address,
    input  logic [7:0]         entry_rank,
    input  logic [5:0]         prefix_length,
    input  ipst_pkg::ipst_cmd_t cmd,
    output ipst_pkg::ipst_stat_t stat,
    output logic [1:0]         status,
    output logic               hit,
    output logic [7:0]         rank_out
);
    import ipst_pkg::*;

    logic [CNT_W-1:0]   count_reg [2];
    logic               active_reg;
    kind_t              kind_reg;
    logic [31:0]        addr_reg;
    logic [7:0]         rank_reg;
    logic [5:0]         plen_reg;
    logic [CNT_W-1:0]   lo_reg, hi_reg, ptr_reg;
    logic [ENTRY_W-1:0] hold_reg;
    logic [1:0]         status_reg;
    logic               hit_reg;
    logic [7:0]         rank_out_reg;
    logic [1:0]         out_status_reg;
    logic               out_hit_reg;
    logic [7:0]         out_rank_reg;

    logic               bank;
    logic [CNT_W-1:0]   n;
    logic [CNT_W-1:0]   mid;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_idx;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [31:0]        rd_addr, mask;
    logic [5:0]         rd_plen;

    assign bank    = (kind_reg == KIND_LOOKUP) ? active_reg : ~active_reg;
    assign n       = count_reg[bank];
    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_addr = hold_reg[ENTRY_W-1 -: 32];
    assign rd_plen = hold_reg[5:0];
    assign mask    = (rd_plen >= 6'd32) ? 32'hFFFF_FFFF :
                     (rd_plen == 6'd0) ? 32'd0 : ~(32'hFFFF_FFFF >> rd_plen);

    always_comb
    begin
        ram_we    = cmd.shift_wr | cmd.put;
        ram_wdata = cmd.put ? {addr_reg, rank_reg, (plen_reg > 6'd32) ? 6'd32 : plen_reg}
                            : hold_reg;
        if (cmd.srch_rd)
        begin
            ram_idx = mid[IDX_W-1:0];
        end
        else if (cmd.shift_rd)
        begin
            ram_idx = IDX_W'(ptr_reg - 1'b1);
        end
        else if (cmd.lk_rd)
        begin
            ram_idx = (kind_reg == KIND_LOOKUP) ? IDX_W'(lo_reg - 1'b1) : lo_reg[IDX_W-1:0];
        end
        else
        begin
            ram_idx = ptr_reg[IDX_W-1:0];
        end
    end

    ipst_ram #(.WIDTH(ENTRY_W), .DEPTH(2 * TABLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  ({bank, ram_idx}),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg[0] <= '0;
            count_reg[1] <= '0;
            active_reg   <= 1'b0;
            kind_reg     <= KIND_BEGIN;
        end
        else
        begin
            if (cmd.load_item)
            begin
                kind_reg <= kind_t'(kind);
            end
            if (cmd.set_begin)
            begin
                count_reg[~active_reg] <= '0;
            end
            if (cmd.set_commit)
            begin
                active_reg <= ~active_reg;
            end
            if (cmd.put)
            begin
                count_reg[bank] <= n + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            addr_reg <= net_address;
            rank_reg <= entry_rank;
            plen_reg <= prefix_length;
        end
        if (cmd.srch_init)
        begin
            lo_reg <= '0;
            hi_reg <= n;
        end
        if (cmd.srch_step)
        begin
            if (kind_reg == KIND_LOOKUP ? (rd_addr <= addr_reg) : (rd_addr < addr_reg))
            begin
                lo_reg <= mid + 1'b1;
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        if (cmd.srch_init)
        begin
            ptr_reg <= n;
        end
        else if (cmd.shift_rd)
        begin
            ptr_reg <= ptr_reg;
        end
        else if (cmd.shift_wr)
        begin
            ptr_reg <= ptr_reg - 1'b1;
        end
        hold_reg <= ram_rdata;
        if (cmd.set_status)
        begin
            status_reg   <= cmd.status;
            hit_reg      <= 1'b0;
            rank_out_reg <= '0;
        end
        if (cmd.lk_eval)
        begin
            status_reg   <= ST_DONE;
            hit_reg      <= ((addr_reg & mask) == rd_addr);
            rank_out_reg <= ((addr_reg & mask) == rd_addr) ? hold_reg[13:6] : 8'd0;
        end
        if (cmd.publish)
        begin
            out_status_reg <= status_reg;
            out_hit_reg    <= hit_reg;
            out_rank_reg   <= rank_out_reg;
        end
    end

    assign stat.kind       = kind_reg;
    assign stat.srch_done  = (lo_reg == hi_reg);
    assign stat.found_dup  = (lo_reg < n) && (rd_addr == addr_reg);
    assign stat.full       = (n >= CNT_W'(TABLE_DEPTH));
    assign stat.shift_done = (ptr_reg == lo_reg);
    assign stat.lk_skip    = !table_enable || (lo_reg == '0);

    assign status   = out_status_reg;
    assign hit      = out_hit_reg;
    assign rank_out = out_rank_reg;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg[0] <= CNT_W'(TABLE_DEPTH)) && (count_reg[1] <= CNT_W'(TABLE_DEPTH)))
        else $error("bank count above depth");
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.srch_step |-> lo_reg < hi_reg)
        else $error("search step with empty range");
    a_hit_rank: assert property (@(posedge clk) disable iff (!rst_n)
        !hit_reg |-> rank_out_reg == 8'd0 || $past(!rst_n))
        else $error("rank without hit");
`endif
endmodule

// ===== rtl/ipst_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipst_ctrl
// Sequencer for load, insert with shift, commit and binary-search lookup.
// ----------------------------------------------------------------------------
module ipst_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic                 out_fire,
    input  ipst_pkg::ipst_stat_t stat,
    output ipst_pkg::ipst_cmd_t  cmd,
    output logic                 busy,
    output logic                 out_valid
);
    import ipst_pkg::*;

    state_t state_reg, state_next;
    logic   oval_reg, oval_next;
    logic   busy_reg, busy_next;
    logic   pend_reg, pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            oval_reg  <= 1'b0;
            busy_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            oval_reg  <= oval_next;
            busy_reg  <= busy_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_DONE;
        oval_next  = oval_reg && !out_fire;
        busy_next  = busy_reg;
        pend_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load_item = 1'b1;
                    busy_next     = 1'b1;
                    pend_next     = 1'b1;
                end
                if (pend_reg)
                begin
                    case (stat.kind)
                        KIND_BEGIN:
                        begin
                            cmd.set_begin  = 1'b1;
                            cmd.set_status = 1'b1;
                            state_next     = S_OUT;
                        end
                        KIND_COMMIT:
                        begin
                            cmd.set_commit = 1'b1;
                            cmd.set_status = 1'b1;
                            state_next     = S_OUT;
                        end
                        KIND_INSERT:
                        begin
                            cmd.srch_init = 1'b1;
                            state_next    = S_SRCH_RD;
                        end
                        default:
                        begin
                            cmd.srch_init = 1'b1;
                            state_next    = S_SRCH_RD;
                        end
                    endcase
                end
            end
            S_SRCH_RD:
            begin
                if (stat.srch_done)
                begin
                    if (stat.kind == KIND_LOOKUP)
                    begin
                        state_next = S_LK_RD;
                    end
                    else
                    begin
                        state_next = S_LK_RD;
                    end
                end
                else
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_SRCH_WT;
                end
            end
            S_SRCH_WT:
            begin
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                cmd.srch_step = 1'b1;
                state_next    = S_SRCH_RD;
            end
            S_LK_RD:
            begin
                cmd.lk_rd  = 1'b1;
                state_next = S_LK_WT;
            end
            S_LK_WT:
            begin
                state_next = S_LK_CMP;
            end
            S_LK_CMP:
            begin
                if (stat.kind == KIND_LOOKUP)
                begin
                    if (stat.lk_skip)
                    begin
                        cmd.set_status = 1'b1;
                    end
                    else
                    begin
                        cmd.lk_eval = 1'b1;
                    end
                    state_next = S_OUT;
                end
                else if (stat.found_dup)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_DUP;
                    state_next     = S_OUT;
                end
                else if (stat.full)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_FULL;
                    state_next     = S_OUT;
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (stat.shift_done)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WT;
                end
            end
            S_SHIFT_WT:
            begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_PUT:
            begin
                cmd.put        = 1'b1;
                cmd.set_status = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!oval_reg || out_fire)
                begin
                    cmd.publish = 1'b1;
                    oval_next   = 1'b1;
                    busy_next   = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy      = busy_reg;
    assign out_valid = oval_reg;

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> state_reg == S_IDLE && !pend_reg)
        else $error("item accepted while busy");
    a_put_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put |=> !cmd.put)
        else $error("double insert write");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        oval_reg && !out_fire |=> oval_reg)
        else $error("result dropped");
`endif
endmodule

// ===== rtl/ip_prefix_sorted_table.sv =====
// ----------------------------------------------------------------------------
// ip_prefix_sorted_table
// Double-banked sorted IPv4 prefix table with binary-search lookup.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         request: kind in tuser, address/rank/prefix in tdata
// m_axis    out        result: status/hit/rank in tdata
// cfg       in         table_enable write
// A lookup runs k binary-search steps, k being about log2 of the count plus
// one, with one RAM read per step. An insert runs the same search, then
// shifts each later entry by one place; a duplicate or full insert stops before
// any shift. Begin load and commit do no search. One request is handled at a time.
// Reset clears counts and the active bank; entry RAM needs no clearing.
// A request is accepted while a result waits; its own result then waits until taken.
module ip_prefix_sorted_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // kind
    input  logic [47:0] s_axis_tdata,   // net_address, entry_rank, prefix_length
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // status, hit, rank_out
);
    import ipst_pkg::*;

    logic       enable_reg;
    ipst_cmd_t  cmd;
    ipst_stat_t stat;
    logic       busy, in_fire, out_fire;
    logic [1:0] status;
    logic       hit;
    logic [7:0] rank_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            enable_reg <= cfg_wdata;
        end
    end

    assign s_axis_tready = !busy;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    ipst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .out_valid (m_axis_tvalid)
    );

    ipst_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .table_enable  (enable_reg),
        .kind          (s_axis_tuser),
        .net_address   (s_axis_tdata[31:0]),
        .entry_rank    (s_axis_tdata[39:32]),
        .prefix_length (s_axis_tdata[45:40]),
        .cmd           (cmd),
        .stat          (stat),
        .status        (status),
        .hit           (hit),
        .rank_out      (rank_out)
    );

    assign m_axis_tdata = {5'd0, rank_out, hit, status};
endmodule
